>>> design/address_range_line_lookup_table_assert.svh
// Assertion macros for the address range and line lookup table.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ADDRESS_RANGE_LINE_LOOKUP_TABLE_ASSERT_SVH
`define ADDRESS_RANGE_LINE_LOOKUP_TABLE_ASSERT_SVH

// Check that a condition holds in the cycle after the trigger.
`define ARLT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

// Check that a condition holds in the same cycle as the trigger.
`define ARLT_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

`endif

>>> design/arltt_pkg.sv
// Shared types and constants for the address range and line lookup table.
// No dependencies.
package arltt_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 64;
  localparam int LEN_W  = 32;
  localparam int UNIT_W = 32;
  localparam int LNUM_W = 32;
  localparam int COL_W  = 16;

  localparam logic [FUNC_W-1:0] FUNC_ADD_RANGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_LINE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP    = 2'd2;

  // Range word: {start, length, unit}
  localparam int RWORD_W = ADDR_W + LEN_W + UNIT_W;
  // Line word: {start, end, unit, number, column}
  localparam int LWORD_W = ADDR_W + ADDR_W + UNIT_W + LNUM_W + COL_W;
  localparam int LEND_LSB = UNIT_W + LNUM_W + COL_W;

  // Per-ring control between the sequencer and a ring of cells
  typedef struct packed {
    logic shift;
    logic wr_en;
    logic upd_en;
  } ring_ctl_t;

endpackage

>>> design/arltt_cell.sv
// One storage cell of a rotating ring: holds one table entry.
// Uses arltt_pkg conventions only through its parent.
module arltt_cell #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         wr,
  input  logic         upd,
  input  logic [W-1:0] nbr,
  input  logic [W-1:0] wdata,
  input  logic [W-1:0] umask,
  input  logic [W-1:0] udata,
  output logic [W-1:0] q
);
  logic [W-1:0] q_r, q_nxt;

  // Take neighbor on rotate, else full or masked write
  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = nbr;
    end else if (wr) begin
      q_nxt = wdata;
    end else if (upd) begin
      q_nxt = (q_r & ~umask) | (udata & umask);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;
endmodule

>>> design/arltt_ring.sv
// Ring of cells that rotates its entries past a head tap, one cell a cycle while shift is set.
// Depends on arltt_pkg and arltt_cell.
module arltt_ring #(
  parameter int DEPTH = 64,
  parameter int W     = 32
) (
  input  logic                      clk,
  input  arltt_pkg::ring_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0]  wr_idx,
  input  logic [W-1:0]              wr_data,
  input  logic [$clog2(DEPTH)-1:0]  upd_idx,
  input  logic [W-1:0]              upd_mask,
  input  logic [W-1:0]              upd_data,
  output logic [W-1:0]              head
);
  import arltt_pkg::*;
  localparam int IW = $clog2(DEPTH);

  logic [W-1:0] q [DEPTH];

  // Each cell takes from the next one; the last wraps to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IW-1:0] my_idx;
    assign my_idx = IW'(i);
    arltt_cell #(.W(W)) u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .wr    (ctl.wr_en && (wr_idx == my_idx)),
      .upd   (ctl.upd_en && (upd_idx == my_idx)),
      .nbr   (q[(i + 1) % DEPTH]),
      .wdata (wr_data),
      .umask (upd_mask),
      .udata (upd_data),
      .q     (q[i])
    );
  end

  assign head = q[0];
endmodule

>>> design/address_range_line_lookup_table.sv
// Top level: address range table and source line table with lookup.
// Depends on arltt_pkg, arltt_ring, arltt_cell and the assertion header.
//
//  channel | dir  | handshake            | payload
//  in      | in   | in_valid / in_ready  | func, address, length, unit_id, line_no, ...
//  out     | out  | out_valid / out_ready| ok, found_unit, low_pc, high_pc, ...
//
// Each table is a ring of cells that rotates one entry per cycle past a head
// comparator while it is searched; a search is one full turn of the ring.
// Reset clears fill counts and batch state; no clearing pass is needed.
// A new item is taken while an earlier result waits on out_ready.
module address_range_line_lookup_table #(
  parameter int RANGE_ENTRIES = 64,
  parameter int LINE_ENTRIES  = 1024,
  parameter int UNIT_ENTRIES  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arltt_pkg::FUNC_W-1:0]  in_func,
  input  logic [arltt_pkg::ADDR_W-1:0]  in_address,
  input  logic [arltt_pkg::LEN_W-1:0]   in_length,
  input  logic [arltt_pkg::UNIT_W-1:0]  in_unit_id,
  input  logic [arltt_pkg::LNUM_W-1:0]  in_line_no,
  input  logic [arltt_pkg::COL_W-1:0]   in_column,
  input  logic                          in_end_seq,
  input  logic                          in_first_of_batch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [arltt_pkg::UNIT_W-1:0]  out_found_unit,
  output logic [arltt_pkg::ADDR_W-1:0]  out_low_pc,
  output logic [arltt_pkg::ADDR_W-1:0]  out_high_pc,
  output logic [arltt_pkg::LNUM_W-1:0]  out_found_line,
  output logic [arltt_pkg::COL_W-1:0]   out_found_column
);
  import arltt_pkg::*;

  `include "address_range_line_lookup_table_assert.svh"

  localparam int RIW  = $clog2(RANGE_ENTRIES);
  localparam int LIW  = $clog2(LINE_ENTRIES);
  localparam int UIW  = $clog2(UNIT_ENTRIES);
  localparam int RCW  = $clog2(RANGE_ENTRIES + 1);
  localparam int LCW  = $clog2(LINE_ENTRIES + 1);
  localparam int UCW  = $clog2(UNIT_ENTRIES + 1);
  localparam int MAXD0 = (RANGE_ENTRIES > LINE_ENTRIES) ? RANGE_ENTRIES : LINE_ENTRIES;
  localparam int MAXD  = (MAXD0 > UNIT_ENTRIES) ? MAXD0 : UNIT_ENTRIES;
  localparam int SW   = $clog2(MAXD);
  localparam int CMPW = SW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_USCAN = 4'd1;
  localparam logic [3:0] S_UWR   = 4'd2;
  localparam logic [3:0] S_LDEC  = 4'd3;
  localparam logic [3:0] S_LSCAN = 4'd4;
  localparam logic [3:0] S_LWR   = 4'd5;
  localparam logic [3:0] S_RSCAN = 4'd6;
  localparam logic [3:0] S_RWR   = 4'd7;
  localparam logic [3:0] S_QR    = 4'd8;
  localparam logic [3:0] S_QRDEC = 4'd9;
  localparam logic [3:0] S_QL    = 4'd10;
  localparam logic [3:0] S_QLDEC = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // Control state
  logic [3:0]      state_r, state_nxt;
  logic [SW-1:0]   scnt_r, scnt_nxt;
  logic [RCW-1:0]  rcnt_r, rcnt_nxt;
  logic [LCW-1:0]  lcnt_r, lcnt_nxt;
  logic [UCW-1:0]  ucnt_r, ucnt_nxt;
  logic            ignored_r, ignored_nxt;
  logic            seqend_r, seqend_nxt;
  logic            pvalid_r, pvalid_nxt;
  logic [LIW-1:0]  prev_r, prev_nxt;
  logic [UNIT_W-1:0] bunit_r, bunit_nxt;
  logic            ovalid_r, ovalid_nxt;

  // Captured item
  logic [FUNC_W-1:0] func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [UNIT_W-1:0] uid_r;
  logic [LNUM_W-1:0] lno_r;
  logic [COL_W-1:0]  col_r;
  logic              eseq_r;
  logic              fob_r;

  // Search accumulators
  logic              hit_r, hit_nxt;
  logic [LIW-1:0]    hidx_r, hidx_nxt;
  logic              bv_r, bv_nxt;
  logic [ADDR_W-1:0] bs_r, bs_nxt;
  logic [ADDR_W-1:0] be_r, be_nxt;
  logic [LEN_W-1:0]  bl_r, bl_nxt;
  logic [UNIT_W-1:0] bu_r, bu_nxt;
  logic [LNUM_W-1:0] bn_r, bn_nxt;
  logic [COL_W-1:0]  bc_r, bc_nxt;
  logic [UNIT_W-1:0] qunit_r, qunit_nxt;

  // Result staging and output registers
  logic              res_ok_r, res_ok_nxt;
  logic [UNIT_W-1:0] res_unit_r, res_unit_nxt;
  logic [ADDR_W-1:0] res_lo_r, res_lo_nxt;
  logic [ADDR_W-1:0] res_hi_r, res_hi_nxt;
  logic [LNUM_W-1:0] res_line_r, res_line_nxt;
  logic [COL_W-1:0]  res_col_r, res_col_nxt;
  logic              o_ok_r;
  logic [UNIT_W-1:0] o_unit_r;
  logic [ADDR_W-1:0] o_lo_r, o_hi_r;
  logic [LNUM_W-1:0] o_line_r;
  logic [COL_W-1:0]  o_col_r;

  // Ring ports
  ring_ctl_t r_ctl, l_ctl, u_ctl;
  logic [RWORD_W-1:0] r_head, r_wdata;
  logic [LWORD_W-1:0] l_head, l_wdata, l_umask, l_udata;
  logic [UNIT_W-1:0]  u_head, u_wdata;
  logic [RIW-1:0]     r_widx;
  logic [LIW-1:0]     l_widx, l_uidx;
  logic [UIW-1:0]     u_widx;

  logic [ADDR_W-1:0] rh_start, lh_start, lh_end;
  logic [LEN_W-1:0]  rh_len;
  logic [UNIT_W-1:0] rh_unit, lh_unit;
  logic [LNUM_W-1:0] lh_num;
  logic [COL_W-1:0]  lh_col;
  logic              in_xfer, r_used, l_used, u_used, cov;
  logic [ADDR_W-1:0] bs_last;

  assign {rh_start, rh_len, rh_unit} = r_head;
  assign {lh_start, lh_end, lh_unit, lh_num, lh_col} = l_head;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Head slot is in use when its index is below the fill count
  assign r_used = CMPW'(scnt_r) < CMPW'(rcnt_r);
  assign l_used = CMPW'(scnt_r) < CMPW'(lcnt_r);
  assign u_used = CMPW'(scnt_r) < CMPW'(ucnt_r);

  // Last address covered by the best range, wrapping
  assign bs_last = bs_r + {{(ADDR_W-LEN_W){1'b0}}, bl_r} - ADDR_W'(1);
  assign cov     = (addr_r <= bs_last);

  assign r_widx  = rcnt_r[RIW-1:0];
  assign l_widx  = lcnt_r[LIW-1:0];
  assign u_widx  = ucnt_r[UIW-1:0];
  assign l_uidx  = prev_r;
  assign r_wdata = {addr_r, len_r, uid_r};
  assign l_wdata = {addr_r, {ADDR_W{1'b0}}, bunit_r, lno_r, col_r};
  assign u_wdata = uid_r;
  assign l_umask = {{ADDR_W{1'b0}}, {ADDR_W{1'b1}}, {LEND_LSB{1'b0}}};
  assign l_udata = {{ADDR_W{1'b0}}, addr_r - ADDR_W'(1), {LEND_LSB{1'b0}}};

  // Sequencer: scans, decisions and table writes
  always_comb begin
    state_nxt   = state_r;
    scnt_nxt    = scnt_r;
    rcnt_nxt    = rcnt_r;
    lcnt_nxt    = lcnt_r;
    ucnt_nxt    = ucnt_r;
    ignored_nxt = ignored_r;
    seqend_nxt  = seqend_r;
    pvalid_nxt  = pvalid_r;
    prev_nxt    = prev_r;
    bunit_nxt   = bunit_r;
    ovalid_nxt  = ovalid_r;
    hit_nxt     = hit_r;
    hidx_nxt    = hidx_r;
    bv_nxt      = bv_r;
    bs_nxt      = bs_r;
    be_nxt      = be_r;
    bl_nxt      = bl_r;
    bu_nxt      = bu_r;
    bn_nxt      = bn_r;
    bc_nxt      = bc_r;
    qunit_nxt   = qunit_r;
    res_ok_nxt   = res_ok_r;
    res_unit_nxt = res_unit_r;
    res_lo_nxt   = res_lo_r;
    res_hi_nxt   = res_hi_r;
    res_line_nxt = res_line_r;
    res_col_nxt  = res_col_r;
    r_ctl = '0;
    l_ctl = '0;
    u_ctl = '0;

    // Drop the output once it is taken
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          scnt_nxt     = '0;
          hit_nxt      = 1'b0;
          bv_nxt       = 1'b0;
          res_ok_nxt   = 1'b0;
          res_unit_nxt = '0;
          res_lo_nxt   = '0;
          res_hi_nxt   = '0;
          res_line_nxt = '0;
          res_col_nxt  = '0;
          case (in_func)
            FUNC_ADD_RANGE: state_nxt = S_RSCAN;
            FUNC_ADD_LINE:  state_nxt = in_first_of_batch ? S_USCAN : S_LDEC;
            FUNC_LOOKUP:    state_nxt = S_QR;
            default:        state_nxt = S_FIN;
          endcase
        end
      end
      S_USCAN: begin
        u_ctl.shift = 1'b1;
        if (u_used && (u_head == uid_r)) begin
          hit_nxt = 1'b1;
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == SW'(UNIT_ENTRIES - 1)) begin
          scnt_nxt  = '0;
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        ignored_nxt = 1'b1;
        pvalid_nxt  = 1'b0;
        seqend_nxt  = 1'b1;
        prev_nxt    = '0;
        if (!hit_r && (ucnt_r != UCW'(UNIT_ENTRIES))) begin
          u_ctl.wr_en = 1'b1;
          ucnt_nxt    = ucnt_r + UCW'(1);
          bunit_nxt   = uid_r;
          ignored_nxt = 1'b0;
        end
        state_nxt = S_LDEC;
      end
      S_LDEC: begin
        state_nxt = S_FIN;
        if (!ignored_r) begin
          if (eseq_r) begin
            if (pvalid_r) begin
              l_ctl.upd_en = 1'b1;
              seqend_nxt   = 1'b1;
              res_ok_nxt   = 1'b1;
            end
          end else begin
            hit_nxt   = 1'b0;
            state_nxt = S_LSCAN;
          end
        end
      end
      S_LSCAN: begin
        l_ctl.shift = 1'b1;
        if (l_used && !hit_r && (lh_unit == bunit_r) && (lh_start == addr_r)) begin
          hit_nxt  = 1'b1;
          hidx_nxt = scnt_r[LIW-1:0];
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == SW'(LINE_ENTRIES - 1)) begin
          scnt_nxt  = '0;
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        state_nxt = S_FIN;
        if (hit_r || (lcnt_r != LCW'(LINE_ENTRIES))) begin
          if (!hit_r) begin
            l_ctl.wr_en = 1'b1;
            lcnt_nxt    = lcnt_r + LCW'(1);
          end
          if (!seqend_r && pvalid_r) begin
            l_ctl.upd_en = 1'b1;
          end
          seqend_nxt = 1'b0;
          prev_nxt   = hit_r ? hidx_r : l_widx;
          pvalid_nxt = 1'b1;
          res_ok_nxt = 1'b1;
        end
      end
      S_RSCAN: begin
        r_ctl.shift = 1'b1;
        if (r_used) begin
          if (rh_start == addr_r) begin
            hit_nxt = 1'b1;
          end
          if ((rh_start < addr_r) && (!bv_r || (rh_start > bs_r))) begin
            bv_nxt = 1'b1;
            bs_nxt = rh_start;
            bl_nxt = rh_len;
          end
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == SW'(RANGE_ENTRIES - 1)) begin
          scnt_nxt  = '0;
          state_nxt = S_RWR;
        end
      end
      S_RWR: begin
        state_nxt = S_FIN;
        if (!hit_r && !(bv_r && cov) && (rcnt_r != RCW'(RANGE_ENTRIES))) begin
          r_ctl.wr_en = 1'b1;
          rcnt_nxt    = rcnt_r + RCW'(1);
          res_ok_nxt  = 1'b1;
        end
      end
      S_QR: begin
        r_ctl.shift = 1'b1;
        if (r_used && (rh_start <= addr_r) && (!bv_r || (rh_start > bs_r))) begin
          bv_nxt = 1'b1;
          bs_nxt = rh_start;
          bl_nxt = rh_len;
          bu_nxt = rh_unit;
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == SW'(RANGE_ENTRIES - 1)) begin
          scnt_nxt  = '0;
          state_nxt = S_QRDEC;
        end
      end
      S_QRDEC: begin
        if (bv_r && cov) begin
          qunit_nxt = bu_r;
          bv_nxt    = 1'b0;
          state_nxt = S_QL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_QL: begin
        l_ctl.shift = 1'b1;
        if (l_used && (lh_unit == qunit_r) && (lh_start <= addr_r) &&
            (!bv_r || (lh_start > bs_r))) begin
          bv_nxt = 1'b1;
          bs_nxt = lh_start;
          be_nxt = lh_end;
          bu_nxt = lh_unit;
          bn_nxt = lh_num;
          bc_nxt = lh_col;
        end
        scnt_nxt = scnt_r + SW'(1);
        if (scnt_r == SW'(LINE_ENTRIES - 1)) begin
          scnt_nxt  = '0;
          state_nxt = S_QLDEC;
        end
      end
      S_QLDEC: begin
        if (bv_r && (addr_r <= be_r)) begin
          res_ok_nxt   = 1'b1;
          res_unit_nxt = bu_r;
          res_lo_nxt   = bs_r;
          res_hi_nxt   = be_r;
          res_line_nxt = bn_r;
          res_col_nxt  = bc_r;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hand over once the output register is free
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      scnt_r    <= '0;
      rcnt_r    <= '0;
      lcnt_r    <= '0;
      ucnt_r    <= '0;
      ignored_r <= 1'b1;
      seqend_r  <= 1'b1;
      pvalid_r  <= 1'b0;
      prev_r    <= '0;
      bunit_r   <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scnt_r    <= scnt_nxt;
      rcnt_r    <= rcnt_nxt;
      lcnt_r    <= lcnt_nxt;
      ucnt_r    <= ucnt_nxt;
      ignored_r <= ignored_nxt;
      seqend_r  <= seqend_nxt;
      pvalid_r  <= pvalid_nxt;
      prev_r    <= prev_nxt;
      bunit_r   <= bunit_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Payload, search and result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      addr_r <= in_address;
      len_r  <= in_length;
      uid_r  <= in_unit_id;
      lno_r  <= in_line_no;
      col_r  <= in_column;
      eseq_r <= in_end_seq;
      fob_r  <= in_first_of_batch;
    end
    hit_r      <= hit_nxt;
    hidx_r     <= hidx_nxt;
    bv_r       <= bv_nxt;
    bs_r       <= bs_nxt;
    be_r       <= be_nxt;
    bl_r       <= bl_nxt;
    bu_r       <= bu_nxt;
    bn_r       <= bn_nxt;
    bc_r       <= bc_nxt;
    qunit_r    <= qunit_nxt;
    res_ok_r   <= res_ok_nxt;
    res_unit_r <= res_unit_nxt;
    res_lo_r   <= res_lo_nxt;
    res_hi_r   <= res_hi_nxt;
    res_line_r <= res_line_nxt;
    res_col_r  <= res_col_nxt;
    if ((state_r == S_FIN) && (!ovalid_r || out_ready)) begin
      o_ok_r   <= res_ok_r;
      o_unit_r <= res_unit_r;
      o_lo_r   <= res_lo_r;
      o_hi_r   <= res_hi_r;
      o_line_r <= res_line_r;
      o_col_r  <= res_col_r;
    end
  end

  // Range, line and unit rings
  arltt_ring #(.DEPTH(RANGE_ENTRIES), .W(RWORD_W)) u_range_ring (
    .clk      (clk),
    .ctl      (r_ctl),
    .wr_idx   (r_widx),
    .wr_data  (r_wdata),
    .upd_idx  ('0),
    .upd_mask ('0),
    .upd_data ('0),
    .head     (r_head)
  );

  arltt_ring #(.DEPTH(LINE_ENTRIES), .W(LWORD_W)) u_line_ring (
    .clk      (clk),
    .ctl      (l_ctl),
    .wr_idx   (l_widx),
    .wr_data  (l_wdata),
    .upd_idx  (l_uidx),
    .upd_mask (l_umask),
    .upd_data (l_udata),
    .head     (l_head)
  );

  arltt_ring #(.DEPTH(UNIT_ENTRIES), .W(UNIT_W)) u_unit_ring (
    .clk      (clk),
    .ctl      (u_ctl),
    .wr_idx   (u_widx),
    .wr_data  (u_wdata),
    .upd_idx  ('0),
    .upd_mask ('0),
    .upd_data ('0),
    .head     (u_head)
  );

  assign out_valid        = ovalid_r;
  assign out_ok           = o_ok_r;
  assign out_found_unit   = o_unit_r;
  assign out_low_pc       = o_lo_r;
  assign out_high_pc      = o_hi_r;
  assign out_found_line   = o_line_r;
  assign out_found_column = o_col_r;

  // Assertions
  `ARLT_ASSERT_NEXT(a_accept_busy, in_xfer, state_r != S_IDLE, "idle after accept")
  `ARLT_ASSERT_NOW(a_rcnt_max, 1'b1, rcnt_r <= RCW'(RANGE_ENTRIES), "range count overflow")
  `ARLT_ASSERT_NOW(a_lcnt_max, 1'b1, lcnt_r <= LCW'(LINE_ENTRIES), "line count overflow")
  `ARLT_ASSERT_NOW(a_miss_zero, ovalid_r && !o_ok_r, (o_lo_r == '0) && (o_hi_r == '0),
    "miss with nonzero span")
  `ARLT_ASSERT_NOW(a_fob_path, (state_r == S_USCAN), fob_r && (func_r == FUNC_ADD_LINE),
    "unit scan without batch start")
endmodule
